// ===== design/dpa_pkg.sv =====
package dpa_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int TICK_W      = 16;
   localparam int HOURS_W     = 20;
   localparam int MINSEC_W    = 6;

   localparam logic [CSR_INDEX_W-1:0] CSR_RUN_SECS         = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAUSE_SECS       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALARM_DELAY_SECS = 2'd2;

   localparam logic [TICK_W-1:0] RUN_SECS_RESET    = 16'd10;
   localparam logic [TICK_W-1:0] PAUSE_SECS_RESET  = 16'd5;
   localparam logic [TICK_W-1:0] ALARM_DELAY_RESET = 16'd3;
   localparam logic [TICK_W-1:0] TICK_MAX          = 16'hFFFF;

   localparam logic [HOURS_W-1:0]  HOURS_MAX = 20'hFFFFF;
   localparam logic [MINSEC_W-1:0] LAST_SEC  = 6'd59;
   localparam logic [MINSEC_W-1:0] LAST_MIN  = 6'd59;

   typedef enum logic [1:0] {
      PH_FIRST = 2'd0,
      PH_RUN   = 2'd1,
      PH_PAUSE = 2'd2,
      PH_HALT  = 2'd3
   } phase_type;

   typedef struct packed {
      logic [HOURS_W-1:0]  hours;
      logic [MINSEC_W-1:0] minutes;
      logic [MINSEC_W-1:0] seconds;
   } run_time_type;

   // one second more, holding at the top
   function automatic run_time_type run_time_incr(input run_time_type t);
      run_time_type r;
      r = t;
      if (!(t.hours == HOURS_MAX && t.minutes >= LAST_MIN && t.seconds >= LAST_SEC)) begin
         if (t.seconds >= LAST_SEC) begin
            r.seconds = '0;
            if (t.minutes >= LAST_MIN) begin
               r.minutes = '0;
               r.hours   = t.hours + 1'b1;
            end else begin
               r.minutes = t.minutes + 1'b1;
            end
         end else begin
            r.seconds = t.seconds + 1'b1;
         end
      end
      return r;
   endfunction

endpackage

// ===== design/duplex_pump_alternator.sv =====
// Duplex pump alternator.
// Each req_ word is one one-second tick carrying the alarm level of both pumps
// and a stop request. Each accepted word yields exactly one rsp_ word with the
// pump drive levels, trip and skip flags, the halted flag and both pumps'
// accumulated run time (h:m:s, saturating) after that tick.
// Latency: the rsp_ word is valid the cycle after the req_ word is accepted.
// Throughput: one word per cycle while rsp_ready is high; the tick update is a
// single pass of logic between the state registers and the rsp_ output register.
// req_ready is high while the output register is empty or being taken, so a
// stalled receiver (rsp_ready low) holds the pending rsp_ word unchanged and
// stops intake until it is taken.
// Reset: pump 1 gets the first turn, run-time counters clear, registers return
// to run 10 s, pause 5 s, alarm delay 3 s, and no rsp_ word is pending.
// csr_ writes (index 0 run, 1 pause, 2 alarm delay) take effect at once;
// other indexes are ignored. Once halted the block stays halted until reset.
module duplex_pump_alternator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_alarm_one,
   input  logic                              req_alarm_two,
   input  logic                              req_stop_request,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_pump_one_on,
   output logic                              rsp_pump_two_on,
   output logic                              rsp_trip,
   output logic                              rsp_skip,
   output logic                              rsp_halted,
   output logic [dpa_pkg::HOURS_W-1:0]       rsp_one_hours,
   output logic [dpa_pkg::MINSEC_W-1:0]      rsp_one_minutes,
   output logic [dpa_pkg::MINSEC_W-1:0]      rsp_one_seconds,
   output logic [dpa_pkg::HOURS_W-1:0]       rsp_two_hours,
   output logic [dpa_pkg::MINSEC_W-1:0]      rsp_two_minutes,
   output logic [dpa_pkg::MINSEC_W-1:0]      rsp_two_seconds,
   input  logic                              csr_wr_en,
   input  logic [dpa_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [dpa_pkg::CSR_DATA_W-1:0]    csr_wr_data
);
   import dpa_pkg::*;

   logic [TICK_W-1:0] run_secs_ff;
   logic [TICK_W-1:0] pause_secs_ff;
   logic [TICK_W-1:0] alarm_delay_ff;

   phase_type         phase_ff, phase_in;
   logic              current_pump_ff, current_pump_in;
   logic [TICK_W-1:0] phase_ticks_ff, phase_ticks_in;
   logic              alarm_seen_ff, alarm_seen_in;
   logic [TICK_W-1:0] delay_ticks_ff, delay_ticks_in;
   logic              stop_pending_ff, stop_pending_in;
   run_time_type      run_time_ff [2];
   run_time_type      run_time_in [2];

   logic              rsp_valid_ff, rsp_valid_in;
   logic              pump_one_on_ff, pump_two_on_ff, trip_ff, skip_ff, halted_ff;
   run_time_type      rsp_time_ff [2];

   logic accept;
   logic alarm_cur;
   logic begin_turn, check_alarm, consumed;
   logic trip_w, skip_w;
   logic on_w [2];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign alarm_cur = current_pump_ff ? req_alarm_two : req_alarm_one;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_secs_ff    <= RUN_SECS_RESET;
         pause_secs_ff  <= PAUSE_SECS_RESET;
         alarm_delay_ff <= ALARM_DELAY_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_RUN_SECS:         run_secs_ff    <= csr_wr_data;
            CSR_PAUSE_SECS:       pause_secs_ff  <= csr_wr_data;
            CSR_ALARM_DELAY_SECS: alarm_delay_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      stop_pending_in = stop_pending_ff | req_stop_request;
      phase_in        = phase_ff;
      current_pump_in = current_pump_ff;
      phase_ticks_in  = phase_ticks_ff;
      alarm_seen_in   = alarm_seen_ff;
      delay_ticks_in  = delay_ticks_ff;
      begin_turn      = 1'b0;
      check_alarm     = 1'b0;
      consumed        = 1'b0;
      trip_w          = 1'b0;
      skip_w          = 1'b0;
      on_w[0]         = 1'b0;
      on_w[1]         = 1'b0;

      case (phase_ff)
         PH_FIRST: begin
            begin_turn = 1'b1;
         end
         PH_PAUSE: begin
            if (phase_ticks_ff >= pause_secs_ff) begin
               if (stop_pending_in) begin
                  phase_in = PH_HALT;
               end else begin
                  begin_turn  = 1'b1;
                  check_alarm = 1'b1;
               end
            end
         end
         default: ;
      endcase

      if (begin_turn) begin
         if ((check_alarm && alarm_cur) || run_secs_ff == '0) begin
            skip_w          = check_alarm && alarm_cur;
            current_pump_in = ~current_pump_ff;
            phase_in        = PH_PAUSE;
            phase_ticks_in  = TICK_W'(1);
            consumed        = 1'b1;
         end else begin
            phase_in       = PH_RUN;
            phase_ticks_in = '0;
            alarm_seen_in  = 1'b0;
            delay_ticks_in = '0;
         end
      end

      if (!consumed && phase_in == PH_RUN) begin
         if (alarm_seen_in) begin
            if (delay_ticks_in < alarm_delay_ff) begin
               delay_ticks_in = delay_ticks_in + 1'b1;
            end
            trip_w = alarm_cur && delay_ticks_in >= alarm_delay_ff;
         end else if (alarm_cur) begin
            alarm_seen_in  = 1'b1;
            delay_ticks_in = '0;
            trip_w         = alarm_delay_ff == '0;
         end
         if (trip_w) begin
            current_pump_in = ~current_pump_ff;
            phase_in        = PH_PAUSE;
            phase_ticks_in  = TICK_W'(1);
         end else begin
            on_w[current_pump_ff] = 1'b1;
            if (phase_ticks_in != TICK_MAX) begin
               phase_ticks_in = phase_ticks_in + 1'b1;
            end
            if (phase_ticks_in >= run_secs_ff &&
                !(alarm_seen_in && delay_ticks_in < alarm_delay_ff)) begin
               current_pump_in = ~current_pump_ff;
               phase_in        = PH_PAUSE;
               phase_ticks_in  = '0;
            end
         end
      end else if (!consumed && phase_in == PH_PAUSE) begin
         if (phase_ticks_in != TICK_MAX) begin
            phase_ticks_in = phase_ticks_in + 1'b1;
         end
      end

      for (int i = 0; i < 2; i++) begin
         run_time_in[i] = on_w[i] ? run_time_incr(run_time_ff[i]) : run_time_ff[i];
      end

      rsp_valid_in = accept ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_FIRST;
         current_pump_ff <= 1'b0;
         phase_ticks_ff  <= '0;
         alarm_seen_ff   <= 1'b0;
         delay_ticks_ff  <= '0;
         stop_pending_ff <= 1'b0;
         run_time_ff[0]  <= '0;
         run_time_ff[1]  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff        <= phase_in;
            current_pump_ff <= current_pump_in;
            phase_ticks_ff  <= phase_ticks_in;
            alarm_seen_ff   <= alarm_seen_in;
            delay_ticks_ff  <= delay_ticks_in;
            stop_pending_ff <= stop_pending_in;
            run_time_ff[0]  <= run_time_in[0];
            run_time_ff[1]  <= run_time_in[1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pump_one_on_ff <= on_w[0];
         pump_two_on_ff <= on_w[1];
         trip_ff        <= trip_w;
         skip_ff        <= skip_w;
         halted_ff      <= phase_in == PH_HALT;
         rsp_time_ff[0] <= run_time_in[0];
         rsp_time_ff[1] <= run_time_in[1];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pump_one_on = pump_one_on_ff;
   assign rsp_pump_two_on = pump_two_on_ff;
   assign rsp_trip        = trip_ff;
   assign rsp_skip        = skip_ff;
   assign rsp_halted      = halted_ff;
   assign rsp_one_hours   = rsp_time_ff[0].hours;
   assign rsp_one_minutes = rsp_time_ff[0].minutes;
   assign rsp_one_seconds = rsp_time_ff[0].seconds;
   assign rsp_two_hours   = rsp_time_ff[1].hours;
   assign rsp_two_minutes = rsp_time_ff[1].minutes;
   assign rsp_two_seconds = rsp_time_ff[1].seconds;

   a_one_pump: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(pump_one_on_ff && pump_two_on_ff))
      else $error("both pumps driven");

   a_flag_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (trip_ff || skip_ff || halted_ff)) |->
      (!pump_one_on_ff && !pump_two_on_ff))
      else $error("pump driven on trip, skip or halt");

   a_halt_holds: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HALT |=> phase_ff == PH_HALT)
      else $error("left halt without reset");

   a_secs_range: assert property (@(posedge clock) disable iff (reset)
      run_time_ff[0].seconds <= LAST_SEC && run_time_ff[1].seconds <= LAST_SEC &&
      run_time_ff[0].minutes <= LAST_MIN && run_time_ff[1].minutes <= LAST_MIN)
      else $error("run time out of range");

   a_tick_counted: assert property (@(posedge clock) disable iff (reset)
      (accept && on_w[0]) |=> run_time_ff[0] != $past(run_time_ff[0]) ||
      $past(run_time_ff[0].hours) == HOURS_MAX)
      else $error("driven tick not counted");

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import dpa_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      bit alarm_one;
      bit alarm_two;
      bit stop_request;
   } tick_word_type;

   typedef struct {
      bit           pump_one_on;
      bit           pump_two_on;
      bit           trip;
      bit           skip;
      bit           halted;
      run_time_type one;
      run_time_type two;
   } pump_status_type;

   logic clock = 0;
   logic reset = 1;

   logic                   req_valid = 0;
   logic                   req_ready;
   logic                   req_alarm_one = 0;
   logic                   req_alarm_two = 0;
   logic                   req_stop_request = 0;
   logic                   rsp_valid;
   logic                   rsp_ready = 0;
   logic                   rsp_pump_one_on;
   logic                   rsp_pump_two_on;
   logic                   rsp_trip;
   logic                   rsp_skip;
   logic                   rsp_halted;
   logic [HOURS_W-1:0]     rsp_one_hours;
   logic [MINSEC_W-1:0]    rsp_one_minutes;
   logic [MINSEC_W-1:0]    rsp_one_seconds;
   logic [HOURS_W-1:0]     rsp_two_hours;
   logic [MINSEC_W-1:0]    rsp_two_minutes;
   logic [MINSEC_W-1:0]    rsp_two_seconds;
   logic                   csr_wr_en = 0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;

   duplex_pump_alternator DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_alarm_one    (req_alarm_one),
      .req_alarm_two    (req_alarm_two),
      .req_stop_request (req_stop_request),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pump_one_on  (rsp_pump_one_on),
      .rsp_pump_two_on  (rsp_pump_two_on),
      .rsp_trip         (rsp_trip),
      .rsp_skip         (rsp_skip),
      .rsp_halted       (rsp_halted),
      .rsp_one_hours    (rsp_one_hours),
      .rsp_one_minutes  (rsp_one_minutes),
      .rsp_one_seconds  (rsp_one_seconds),
      .rsp_two_hours    (rsp_two_hours),
      .rsp_two_minutes  (rsp_two_minutes),
      .rsp_two_seconds  (rsp_two_seconds),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // pump controller shadow state
   logic [TICK_W-1:0] run_cfg   = RUN_SECS_RESET;
   logic [TICK_W-1:0] pause_cfg = PAUSE_SECS_RESET;
   logic [TICK_W-1:0] delay_cfg = ALARM_DELAY_RESET;
   phase_type         ph        = PH_FIRST;
   bit                pump      = 0;
   logic [TICK_W-1:0] ph_ticks  = '0;
   bit                alarm_hit = 0;
   logic [TICK_W-1:0] grace     = '0;
   bit                stop_latched = 0;
   run_time_type      run_time [2] = '{'0, '0};

   tick_word_type   ticks_pending [$];
   pump_status_type status_due [$];
   tick_word_type   next_word;
   pump_status_type status_want;
   pump_status_type status_new;
   bit              req_taken = 0;
   int              idle_pct = 23;
   bit              a1_lvl = 0;
   bit              a2_lvl = 0;

   int mismatches = 0;
   int n_ticks = 0;
   int n_checked = 0;
   int n_trips = 0;
   int n_skips = 0;
   int n_halted = 0;
   int n_settings = 0;

   function automatic run_time_type add_second(run_time_type t);
      if (t.hours == HOURS_MAX && t.minutes == LAST_MIN && t.seconds == LAST_SEC)
         return t;
      if (t.seconds == LAST_SEC) begin
         t.seconds = '0;
         if (t.minutes == LAST_MIN) begin
            t.minutes = '0;
            t.hours   = t.hours + 1'b1;
         end else begin
            t.minutes = t.minutes + 1'b1;
         end
      end else begin
         t.seconds = t.seconds + 1'b1;
      end
      return t;
   endfunction

   task automatic enter_pause();
      pump     = ~pump;
      ph       = PH_PAUSE;
      ph_ticks = TICK_W'(1);
   endtask

   task automatic step_pumps(input tick_word_type w, output pump_status_type s);
      bit [1:0] alarm;
      bit [1:0] on;
      bit       begin_turn;
      bit       check;
      bit       consumed;
      bit       tr;
      bit       sk;
      alarm      = {w.alarm_two, w.alarm_one};
      on         = '0;
      tr         = 0;
      sk         = 0;
      begin_turn = 0;
      check      = 0;
      consumed   = 0;
      if (w.stop_request)
         stop_latched = 1;

      if (ph == PH_PAUSE && ph_ticks >= pause_cfg) begin
         if (stop_latched) begin
            ph = PH_HALT;
         end else begin
            begin_turn = 1;
            check      = 1;
         end
      end else if (ph == PH_FIRST) begin
         begin_turn = 1;
      end

      if (begin_turn) begin
         if (check && alarm[pump]) begin
            sk = 1;
            enter_pause();
            consumed = 1;
         end else if (run_cfg == 0) begin
            enter_pause();
            consumed = 1;
         end else begin
            ph        = PH_RUN;
            ph_ticks  = '0;
            alarm_hit = 0;
            grace     = '0;
         end
      end

      if (!consumed && ph == PH_RUN) begin
         if (alarm_hit) begin
            if (grace < delay_cfg)
               grace = grace + 1'b1;
            tr = alarm[pump] && grace >= delay_cfg;
         end else if (alarm[pump]) begin
            alarm_hit = 1;
            grace     = '0;
            tr        = (delay_cfg == 0);
         end
         if (tr) begin
            enter_pause();
         end else begin
            on[pump]       = 1;
            run_time[pump] = add_second(run_time[pump]);
            if (ph_ticks != TICK_MAX)
               ph_ticks = ph_ticks + 1'b1;
            if (ph_ticks >= run_cfg && !(alarm_hit && grace < delay_cfg)) begin
               pump     = ~pump;
               ph       = PH_PAUSE;
               ph_ticks = '0;
            end
         end
      end else if (!consumed && ph == PH_PAUSE) begin
         if (ph_ticks != TICK_MAX)
            ph_ticks = ph_ticks + 1'b1;
      end

      s.pump_one_on = on[0];
      s.pump_two_on = on[1];
      s.trip        = tr;
      s.skip        = sk;
      s.halted      = (ph == PH_HALT);
      s.one         = run_time[0];
      s.two         = run_time[1];
   endtask

   function automatic void check_field(string name, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // word source
   always @(negedge clock) begin
      if (!req_valid || req_taken) begin
         req_taken = 0;
         if (!reset && ticks_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
            next_word = ticks_pending.pop_front();
            req_valid        <= 1;
            req_alarm_one    <= next_word.alarm_one;
            req_alarm_two    <= next_word.alarm_two;
            req_stop_request <= next_word.stop_request;
         end else begin
            req_valid <= 0;
         end
      end
      rsp_ready <= !reset && ($urandom_range(99) >= idle_pct);
   end

   // check results, then predict for the word taken at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (status_due.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual halted=%0b trip=%0b",
                        $time, rsp_halted, rsp_trip);
               mismatches++;
            end else begin
               status_want = status_due.pop_front();
               check_field("pump_one_on", status_want.pump_one_on, rsp_pump_one_on);
               check_field("pump_two_on", status_want.pump_two_on, rsp_pump_two_on);
               check_field("trip", status_want.trip, rsp_trip);
               check_field("skip", status_want.skip, rsp_skip);
               check_field("halted", status_want.halted, rsp_halted);
               check_field("one_hours", status_want.one.hours, rsp_one_hours);
               check_field("one_minutes", status_want.one.minutes, rsp_one_minutes);
               check_field("one_seconds", status_want.one.seconds, rsp_one_seconds);
               check_field("two_hours", status_want.two.hours, rsp_two_hours);
               check_field("two_minutes", status_want.two.minutes, rsp_two_minutes);
               check_field("two_seconds", status_want.two.seconds, rsp_two_seconds);
               n_checked++;
            end
         end
         if (req_valid && req_ready) begin
            next_word.alarm_one    = req_alarm_one;
            next_word.alarm_two    = req_alarm_two;
            next_word.stop_request = req_stop_request;
            step_pumps(next_word, status_new);
            status_due.push_back(status_new);
            req_taken = 1;
            n_ticks++;
            n_trips  += status_new.trip;
            n_skips  += status_new.skip;
            n_halted += status_new.halted;
         end
      end
   end

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_wr_en   <= 1;
      csr_index   <= idx;
      csr_wr_data <= val;
      case (idx)
         CSR_RUN_SECS:         run_cfg   = val;
         CSR_PAUSE_SECS:       pause_cfg = val;
         CSR_ALARM_DELAY_SECS: delay_cfg = val;
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 0;
   endtask

   task automatic configure(input int run_s, input int pause_s, input int delay_s);
      write_csr(CSR_RUN_SECS, CSR_DATA_W'(run_s));
      write_csr(CSR_PAUSE_SECS, CSR_DATA_W'(pause_s));
      write_csr(CSR_ALARM_DELAY_SECS, CSR_DATA_W'(delay_s));
      n_settings++;
   endtask

   task automatic drain();
      while (ticks_pending.size() > 0 || req_valid || status_due.size() > 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // sticky alarm levels; on/off odds in percent per tick
   task automatic random_ticks(input int n, input int on_pct, input int off_pct,
                               input int stop_pct);
      tick_word_type w;
      for (int i = 0; i < n; i++) begin
         if (a1_lvl) a1_lvl = ($urandom_range(99) >= off_pct);
         else        a1_lvl = ($urandom_range(99) < on_pct);
         if (a2_lvl) a2_lvl = ($urandom_range(99) >= off_pct);
         else        a2_lvl = ($urandom_range(99) < on_pct);
         w.alarm_one    = a1_lvl;
         w.alarm_two    = a2_lvl;
         w.stop_request = ($urandom_range(99) < stop_pct);
         ticks_pending.push_back(w);
      end
   endtask

   initial begin
      tick_word_type w;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // default settings: first-turn grace, trip after grace, skip, both alarms
      for (int i = 0; i < 25; i++) begin
         w.alarm_one    = (i == 0 || i == 3 || (i >= 19 && i <= 22));
         w.alarm_two    = (i == 8 || i == 15 || i == 23);
         w.stop_request = 0;
         ticks_pending.push_back(w);
      end
      random_ticks(150, 6, 30, 0);
      drain();

      // long stretch without idling, zero pause and zero grace
      idle_pct = 0;
      configure(3, 0, 0);
      random_ticks(300, 6, 30, 0);
      drain();
      idle_pct = 23;

      configure(0, 2, 1);
      random_ticks(100, 50, 50, 0);
      drain();

      configure(TICK_MAX, TICK_MAX, TICK_MAX);
      random_ticks(60, 4, 20, 0);
      drain();

      configure(1, 1, 2);
      write_csr(CSR_SPARE, '1);
      random_ticks(150, 8, 30, 0);
      drain();

      configure(0, 0, 0);
      random_ticks(80, 20, 40, 0);
      drain();

      configure(2, 0, 5);
      random_ticks(150, 6, 25, 0);
      drain();

      repeat (4) begin
         configure($urandom_range(1, 12), $urandom_range(0, 6), $urandom_range(0, 8));
         random_ticks(120, 6, 30, 0);
         drain();
      end

      // stop requests only here, since halt holds until reset
      configure(4, 3, 2);
      random_ticks(12, 6, 30, 0);
      w.alarm_one    = 0;
      w.alarm_two    = 0;
      w.stop_request = 1;
      ticks_pending.push_back(w);
      random_ticks(50, 6, 30, 5);
      drain();

      $display("Ran %0d ticks over %0d register settings, %0d words checked",
               n_ticks, n_settings, n_checked);
      $display("Saw %0d trips, %0d skipped turns, %0d halted ticks",
               n_trips, n_skips, n_halted);
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timeout: %0d words still expected", status_due.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule
